@@ rtl/core/cvr_pkg.sv @@
package cvr_pkg;

    localparam int unsigned ONE_Q = 65536;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = -32'sh8000_0000;

    localparam logic CFG_RESTITUTION = 1'b0;
    localparam logic CFG_FRICTION    = 1'b1;

    // clamp a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'(SAT_MAX);
        lo = 66'(SAT_MIN);
        if (x > hi)      sat32 = SAT_MAX;
        else if (x < lo) sat32 = SAT_MIN;
        else             sat32 = x[31:0];
    endfunction

endpackage

@@ rtl/core/cvr_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module cvr_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [65:0] i_rad,
    output logic [32:0] o_root
);
    // 66-bit radicand gives 33 result bits; one stage per bit
    logic [65:0] r_rem  [0:33];
    logic [32:0] r_root [0:33];
    logic [65:0] r_rad  [0:33];

    assign r_rem[0]  = '0;
    assign r_root[0] = '0;
    assign r_rad[0]  = i_rad;

    for (genvar s = 0; s < 33; s++) begin : g_stage
        logic [67:0] n_trial;
        logic [65:0] n_rem;
        always_comb begin
            n_rem   = {r_rem[s][63:0], r_rad[s][65:64]};
            n_trial = {2'b00, n_rem} - {1'b0, 32'(r_root[s]), 2'b01};
        end
        logic [65:0] r_stg_rem;
        logic [32:0] r_stg_root;
        logic [65:0] r_stg_rad;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg_rad <= {r_rad[s][63:0], 2'b00};
                if (!n_trial[67]) begin
                    r_stg_rem  <= n_trial[65:0];
                    r_stg_root <= {r_root[s][31:0], 1'b1};
                end else begin
                    r_stg_rem  <= n_rem;
                    r_stg_root <= {r_root[s][31:0], 1'b0};
                end
            end
        end
        assign r_rem[s+1]  = r_stg_rem;
        assign r_root[s+1] = r_stg_root;
        assign r_rad[s+1]  = r_stg_rad;
    end

    assign o_root = r_root[33];
endmodule

@@ rtl/core/cvr_div.sv @@
// Pipelined restoring divider, unsigned 55-bit quotient of num/den.
module cvr_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [54:0] i_num,
    input  logic [32:0] i_den,
    output logic [54:0] o_quo
);
    logic [54:0] r_num [0:55];
    logic [33:0] r_rem [0:55];
    logic [32:0] r_den [0:55];

    assign r_num[0] = i_num;
    assign r_rem[0] = '0;
    assign r_den[0] = i_den;

    for (genvar s = 0; s < 55; s++) begin : g_stage
        logic [33:0] n_rem;
        logic [34:0] n_sub;
        always_comb begin
            n_rem = {r_rem[s][32:0], r_num[s][54]};
            n_sub = {1'b0, n_rem} - {2'b00, r_den[s]};
        end
        logic [54:0] r_stg_num;
        logic [33:0] r_stg_rem;
        logic [32:0] r_stg_den;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stg_den <= r_den[s];
                r_stg_num <= {r_num[s][53:0], !n_sub[34]};
                r_stg_rem <= n_sub[34] ? n_rem : n_sub[33:0];
            end
        end
        assign r_num[s+1] = r_stg_num;
        assign r_rem[s+1] = r_stg_rem;
        assign r_den[s+1] = r_stg_den;
    end

    assign o_quo = r_num[55];
endmodule

@@ rtl/core/collision_velocity_response.sv @@
// Collision velocity response: restitution and Coulomb friction on one particle
// velocity per beat, Q16.16. Fully pipelined: one item enters every cycle while
// no stall holds, and each result reaches the output register 100 register
// stages after the input beat is taken (seven arithmetic stages, 33 square-root
// stages, one product stage, 55 divider stages and four closing stages set the
// depth). A stall freezes the whole pipe; an output beat waits in the last stage
// while the stall holds. Config registers: 0 restitution, 1 friction.
module collision_velocity_response #(
    parameter int DIMENSION = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [17:0] i_normal_x,
    input  logic signed [17:0] i_normal_y,
    input  logic signed [17:0] i_normal_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic signed [31:0] i_wall_vel_x,
    input  logic signed [31:0] i_wall_vel_y,
    input  logic signed [31:0] i_wall_vel_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_new_vel_x,
    output logic signed [31:0] o_new_vel_y,
    output logic signed [31:0] o_new_vel_z,
    output logic               o_collided
);
    import cvr_pkg::*;

    localparam int LAT_SQ  = 33;
    localparam int LAT_DIV = 55;
    localparam int DEPTH   = 7 + LAT_SQ + 1 + LAT_DIV + 4;

    logic [16:0] r_rest;
    logic [18:0] r_fric;
    logic        w_en;

    assign o_cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest <= '0;
            r_fric <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RESTITUTION: r_rest <= i_cfg_data[16:0];
                CFG_FRICTION:    r_fric <= i_cfg_data[18:0];
                default: ;
            endcase
        end
    end

    // whole pipe advances unless the output is stalled with a beat waiting
    logic [DEPTH-1:0] r_vld;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[DEPTH-2:0], i_valid};
    end

    // delay line for side data that waits across the root and divide pipes
    typedef struct packed {
        logic signed [31:0] wx, wy, wz;
        logic signed [31:0] vx, vy, vz;
        logic signed [31:0] tx, ty, tz;
        logic signed [31:0] nx, ny, nz;
        logic               hit;
        logic               any_t;
    } t_side;

    // ---- stage 1: relative velocity
    logic signed [17:0] r_s1_n [3];
    logic signed [31:0] r_s1_v [3], r_s1_w [3], r_s1_r [3];
    logic [16:0] r_s1_rest;
    logic [18:0] r_s1_fric;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_n[0] <= i_normal_x; r_s1_n[1] <= i_normal_y;
            r_s1_n[2] <= (DIMENSION > 2) ? i_normal_z : 18'sd0;
            r_s1_v[0] <= i_vel_x; r_s1_v[1] <= i_vel_y; r_s1_v[2] <= i_vel_z;
            r_s1_w[0] <= i_wall_vel_x; r_s1_w[1] <= i_wall_vel_y;
            r_s1_w[2] <= i_wall_vel_z;
            r_s1_r[0] <= sat32(66'(i_vel_x) - 66'(i_wall_vel_x));
            r_s1_r[1] <= sat32(66'(i_vel_y) - 66'(i_wall_vel_y));
            r_s1_r[2] <= (DIMENSION > 2) ? sat32(66'(i_vel_z) - 66'(i_wall_vel_z))
                                         : 32'sd0;
            r_s1_rest <= r_rest;
            r_s1_fric <= r_fric;
        end
    end

    // ---- stage 2: products n*rel
    logic signed [49:0] r_s2_p [3];
    logic signed [17:0] r_s2_n [3];
    logic signed [31:0] r_s2_v [3], r_s2_w [3], r_s2_r [3];
    logic [16:0] r_s2_rest;
    logic [18:0] r_s2_fric;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_p[i] <= r_s1_n[i] * r_s1_r[i];
                r_s2_n[i] <= r_s1_n[i]; r_s2_v[i] <= r_s1_v[i];
                r_s2_w[i] <= r_s1_w[i]; r_s2_r[i] <= r_s1_r[i];
            end
            r_s2_rest <= r_s1_rest; r_s2_fric <= r_s1_fric;
        end
    end

    // ---- stage 3: dot sum, approach test, dotq
    logic signed [51:0] w_dot;
    assign w_dot = 52'(r_s2_p[0]) + 52'(r_s2_p[1]) + 52'(r_s2_p[2]);
    logic               r_s3_hit;
    logic signed [31:0] r_s3_dq;
    logic signed [17:0] r_s3_n [3];
    logic signed [31:0] r_s3_v [3], r_s3_w [3], r_s3_r [3];
    logic [16:0] r_s3_rest;
    logic [18:0] r_s3_fric;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_hit <= w_dot[51];
            r_s3_dq  <= sat32(66'(w_dot >>> 16));
            for (int i = 0; i < 3; i++) begin
                r_s3_n[i] <= r_s2_n[i];
                r_s3_v[i] <= r_s2_v[i]; r_s3_w[i] <= r_s2_w[i]; r_s3_r[i] <= r_s2_r[i];
            end
            r_s3_rest <= r_s2_rest; r_s3_fric <= r_s2_fric;
        end
    end

    // ---- stage 4: relN = sat(dotq*n >> 16)
    logic signed [49:0] w_rnp [3];
    always_comb begin
        for (int i = 0; i < 3; i++) w_rnp[i] = r_s3_dq * r_s3_n[i];
    end
    logic signed [31:0] r_s4_rn [3];
    logic               r_s4_hit;
    logic signed [31:0] r_s4_v [3], r_s4_w [3], r_s4_r [3];
    logic [16:0] r_s4_rest;
    logic [18:0] r_s4_fric;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s4_rn[i] <= sat32(66'(w_rnp[i] >>> 16));
                r_s4_v[i] <= r_s3_v[i]; r_s4_w[i] <= r_s3_w[i]; r_s4_r[i] <= r_s3_r[i];
            end
            r_s4_hit <= r_s3_hit; r_s4_rest <= r_s3_rest; r_s4_fric <= r_s3_fric;
        end
    end

    // ---- stage 5: relT, dN, newN
    logic signed [19:0] w_neg_e0, w_neg_e1;
    assign w_neg_e0 = -$signed({3'b000, r_s4_rest});
    assign w_neg_e1 = w_neg_e0 - 20'sd65536;
    logic signed [51:0] w_dnp [3], w_nnp [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dnp[i] = w_neg_e1 * r_s4_rn[i];
            w_nnp[i] = w_neg_e0 * r_s4_rn[i];
        end
    end
    logic signed [31:0] r_s5_t [3], r_s5_dn [3], r_s5_nn [3];
    logic               r_s5_hit;
    logic signed [31:0] r_s5_v [3], r_s5_w [3];
    logic [18:0] r_s5_fric;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s5_t[i]  <= sat32(66'(r_s4_r[i]) - 66'(r_s4_rn[i]));
                r_s5_dn[i] <= sat32(66'(w_dnp[i] >>> 16));
                r_s5_nn[i] <= sat32(66'(w_nnp[i] >>> 16));
                r_s5_v[i] <= r_s4_v[i]; r_s5_w[i] <= r_s4_w[i];
            end
            r_s5_hit <= r_s4_hit; r_s5_fric <= r_s4_fric;
        end
    end

    // ---- stage 6: squares
    logic [63:0] r_s6_dq [3], r_s6_tq [3];
    t_side       r_s6_side;
    logic [18:0] r_s6_fric;
    function automatic logic [31:0] mag(input logic signed [31:0] x);
        mag = x[31] ? 32'(-x) : x;
    endfunction
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s6_dq[i] <= mag(r_s5_dn[i]) * mag(r_s5_dn[i]);
                r_s6_tq[i] <= mag(r_s5_t[i]) * mag(r_s5_t[i]);
            end
            r_s6_side <= '{wx: r_s5_w[0], wy: r_s5_w[1], wz: r_s5_w[2],
                           vx: r_s5_v[0], vy: r_s5_v[1], vz: r_s5_v[2],
                           tx: r_s5_t[0], ty: r_s5_t[1], tz: r_s5_t[2],
                           nx: r_s5_nn[0], ny: r_s5_nn[1], nz: r_s5_nn[2],
                           hit: r_s5_hit,
                           any_t: (r_s5_t[0] != 0) || (r_s5_t[1] != 0) ||
                                  (r_s5_t[2] != 0)};
            r_s6_fric <= r_s5_fric;
        end
    end

    // ---- stage 7: sums of squares (three squares of at most 2^62 fit 64 bits)
    logic [63:0] r_s7_ds, r_s7_ts;
    t_side       r_s7_side;
    logic [18:0] r_s7_fric;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_ds <= r_s6_dq[0] + r_s6_dq[1] + r_s6_dq[2];
            r_s7_ts <= r_s6_tq[0] + r_s6_tq[1] + r_s6_tq[2];
            r_s7_side <= r_s6_side; r_s7_fric <= r_s6_fric;
        end
    end

    // ---- roots of both sums
    logic [32:0] w_nd, w_nt;
    cvr_isqrt u_sqd (.i_clk, .i_en(w_en), .i_rad({2'b00, r_s7_ds}), .o_root(w_nd));
    cvr_isqrt u_sqt (.i_clk, .i_en(w_en), .i_rad({2'b00, r_s7_ts}), .o_root(w_nt));

    t_side       r_sd1 [LAT_SQ];
    logic [18:0] r_fd  [LAT_SQ];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd1[0] <= r_s7_side; r_fd[0] <= r_s7_fric;
            for (int k = 1; k < LAT_SQ; k++) begin
                r_sd1[k] <= r_sd1[k-1]; r_fd[k] <= r_fd[k-1];
            end
        end
    end

    // ---- stage: friction*|dN|
    logic [50:0] w_fn;
    assign w_fn = r_fd[LAT_SQ-1] * w_nd[31:0];
    logic [54:0] r_s8_num;
    logic [32:0] r_s8_den;
    t_side       r_s8_side;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8_num  <= 55'(w_fn);
            r_s8_den  <= (w_nt == 0) ? 33'd1 : w_nt;
            r_s8_side <= r_sd1[LAT_SQ-1];
        end
    end

    logic [54:0] w_q;
    cvr_div u_div (.i_clk, .i_en(w_en), .i_num(r_s8_num), .i_den(r_s8_den), .o_quo(w_q));

    t_side r_sd2 [LAT_DIV];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd2[0] <= r_s8_side;
            for (int k = 1; k < LAT_DIV; k++) r_sd2[k] <= r_sd2[k-1];
        end
    end

    // ---- stage: scale
    logic [16:0] r_s9_sc;
    t_side       r_s9_side;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s9_sc   <= (w_q < 55'(ONE_Q)) ? 17'(55'(ONE_Q) - w_q) : 17'd0;
            r_s9_side <= r_sd2[LAT_DIV-1];
        end
    end

    // ---- stage: tangential products
    logic signed [49:0] r_s10_p [3];
    t_side              r_s10_side;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s10_p[0] <= r_s9_side.tx * $signed({1'b0, r_s9_sc});
            r_s10_p[1] <= r_s9_side.ty * $signed({1'b0, r_s9_sc});
            r_s10_p[2] <= r_s9_side.tz * $signed({1'b0, r_s9_sc});
            r_s10_side <= r_s9_side;
        end
    end

    // ---- stage: newT
    logic signed [33:0] r_s11_t [3];
    t_side              r_s11_side;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s11_t[0] <= r_s10_side.any_t ? 34'(r_s10_p[0] >>> 16) : 34'(r_s10_side.tx);
            r_s11_t[1] <= r_s10_side.any_t ? 34'(r_s10_p[1] >>> 16) : 34'(r_s10_side.ty);
            r_s11_t[2] <= r_s10_side.any_t ? 34'(r_s10_p[2] >>> 16) : 34'(r_s10_side.tz);
            r_s11_side <= r_s10_side;
        end
    end

    // ---- stage: sum and output register
    logic signed [31:0] w_o [3];
    always_comb begin
        w_o[0] = sat32(66'(r_s11_side.nx) + 66'(r_s11_t[0]) + 66'(r_s11_side.wx));
        w_o[1] = sat32(66'(r_s11_side.ny) + 66'(r_s11_t[1]) + 66'(r_s11_side.wy));
        w_o[2] = sat32(66'(r_s11_side.nz) + 66'(r_s11_t[2]) + 66'(r_s11_side.wz));
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_collided  <= r_s11_side.hit;
            o_new_vel_x <= r_s11_side.hit ? w_o[0] : r_s11_side.vx;
            o_new_vel_y <= r_s11_side.hit ? w_o[1] : r_s11_side.vy;
            o_new_vel_z <= (r_s11_side.hit && DIMENSION > 2) ? w_o[2] : r_s11_side.vz;
        end
    end

`ifndef SYNTHESIS
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_new_vel_x)) else $error("beat lost");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("spurious stall");
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_new_vel_y, o_new_vel_z, o_collided}))
        else $error("stalled beat changed");
`endif
endmodule

@@ bench/tb_collision_velocity_response.sv @@
module tb_collision_velocity_response;
    import cvr_pkg::*;

    localparam int PIPE_DEPTH = 100;

    typedef struct {
        logic signed [17:0] nrm [3];
        logic signed [31:0] vel [3];
        logic signed [31:0] wall [3];
    } t_particle;

    typedef struct {
        logic signed [31:0] v [3];
        logic               hit;
    } t_response;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [17:0] i_normal_x, i_normal_y, i_normal_z;
    logic signed [31:0] i_vel_x, i_vel_y, i_vel_z;
    logic signed [31:0] i_wall_vel_x, i_wall_vel_y, i_wall_vel_z;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic               o_collided;

    collision_velocity_response u_dut (.*);

    // bench copy of the two coefficients
    longint    restitution_q;
    longint    friction_q;
    t_response pending_resp [$];
    int        send_gap_pct;
    int        recv_stall_pct;
    int        fail_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // floor of the square root, bitwise restoring method
    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned magnitude(longint c [3]);
        longint unsigned acc, a;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            a = (c[i] < 0) ? -c[i] : c[i];
            acc += a * a;
        end
        return root64(acc);
    endfunction

    function automatic t_response resolve_velocity(t_particle p);
        t_response r;
        longint rel [3], rn [3], rt [3], dn [3];
        longint dotq, nn, tt;
        longint dot;
        longint unsigned scale, q, md, mt;
        bit any_t;
        dot = 0;
        any_t = 0;
        scale = 65536;
        for (int i = 0; i < 3; i++) begin
            r.v[i] = p.vel[i];
            rel[i] = clamp32(longint'(p.vel[i]) - longint'(p.wall[i]));
            dot += longint'(p.nrm[i]) * rel[i];
        end
        r.hit = dot < 0;
        if (r.hit) begin
            dotq = clamp32(dot >>> 16);
            for (int i = 0; i < 3; i++) begin
                rn[i] = clamp32((dotq * longint'(p.nrm[i])) >>> 16);
                rt[i] = clamp32(rel[i] - rn[i]);
                dn[i] = clamp32((-(restitution_q + 65536) * rn[i]) >>> 16);
                if (rt[i] != 0) any_t = 1;
            end
            if (any_t) begin
                md = magnitude(dn);
                mt = magnitude(rt);
                if (mt == 0) mt = 1;
                q = (longint'(friction_q) * md) / mt;
                scale = (q < 65536) ? 65536 - q : 0;
            end
            for (int i = 0; i < 3; i++) begin
                nn = clamp32((-restitution_q * rn[i]) >>> 16);
                tt = any_t ? (rt[i] * longint'(scale)) >>> 16 : rt[i];
                r.v[i] = 32'(clamp32(nn + tt + longint'(p.wall[i])));
            end
        end
        return r;
    endfunction

    // write one coefficient register; the pipe must be drained first
    task automatic write_coeff(logic idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_RESTITUTION) restitution_q = longint'(data & 32'h1FFFF);
        else                        friction_q    = longint'(data & 32'h7FFFF);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain_pipe();
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    // send one beat, with an optional random gap ahead of it
    task automatic send_particle(t_particle p);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_normal_x   = p.nrm[0];
        i_normal_y   = p.nrm[1];
        i_normal_z   = p.nrm[2];
        i_vel_x      = p.vel[0];
        i_vel_y      = p.vel[1];
        i_vel_z      = p.vel[2];
        i_wall_vel_x = p.wall[0];
        i_wall_vel_y = p.wall[1];
        i_wall_vel_z = p.wall[2];
        do @(posedge i_clk); while (o_stall);
        pending_resp.push_back(resolve_velocity(p));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic logic signed [17:0] unit_axis(int s);
        return (s == 0) ? -18'sd65536 : 18'sd65536;
    endfunction

    function automatic logic signed [31:0] rand_vel();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed($urandom_range(2 << 20)) - (1 << 20);
            2:       return $urandom_range(1) ? 32'sh7FFF_FFFF : -32'sh8000_0000;
            default: return $signed($urandom_range(2 << 24)) - (1 << 24);
        endcase
    endfunction

    // unit-axis normals or random components within +-37500, occasionally any 18-bit pattern
    function automatic t_particle rand_particle();
        t_particle p;
        int ax;
        ax = $urandom_range(2);
        for (int i = 0; i < 3; i++) begin
            p.vel[i]  = rand_vel();
            p.wall[i] = ($urandom_range(3) == 0) ? rand_vel() : 32'sd0;
            if ($urandom_range(9) == 0)
                p.nrm[i] = 18'($urandom);
            else if ($urandom_range(1))
                p.nrm[i] = (i == ax) ? unit_axis($urandom_range(1)) : 18'sd0;
            else
                p.nrm[i] = 18'($signed($urandom_range(75000)) - 37500);
        end
        return p;
    endfunction

    // check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_response e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_resp.size() == 0) begin
                $error("unexpected result beat");
                fail_count++;
            end else begin
                e = pending_resp.pop_front();
                if (o_new_vel_x !== e.v[0]) begin
                    $error("new_vel_x exp %0d got %0d", e.v[0], o_new_vel_x);
                    fail_count++;
                end
                if (o_new_vel_y !== e.v[1]) begin
                    $error("new_vel_y exp %0d got %0d", e.v[1], o_new_vel_y);
                    fail_count++;
                end
                if (o_new_vel_z !== e.v[2]) begin
                    $error("new_vel_z exp %0d got %0d", e.v[2], o_new_vel_z);
                    fail_count++;
                end
                if (o_collided !== e.hit) begin
                    $error("collided exp %0d got %0d", e.hit, o_collided);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall, redrawn each falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic test_directed();
        t_particle p;
        for (int k = 0; k < 24; k++) begin
            for (int i = 0; i < 3; i++) begin
                p.nrm[i]  = (i == k % 3) ? unit_axis(k % 2) : 18'sd0;
                p.vel[i]  = 32'sd0;
                p.wall[i] = 32'sd0;
            end
            case (k / 3)
                0: p.vel[k % 3] = (k % 2) ? -32'sd65536 : 32'sd65536;
                1: p.vel = '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh7FFF_FFFF};
                2: p.vel = '{-32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000};
                3: begin
                    p.vel  = '{32'sd100000, -32'sd70000, 32'sd5};
                    p.wall = '{-32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd3};
                end
                4: p.nrm = '{18'sd0, 18'sd0, 18'sd0};
                5: begin
                    p.nrm = '{18'sh20000, 18'sd131071, 18'sh20000};
                    p.vel = '{32'sd1 << 20, -32'sd1 << 22, 32'sd7};
                end
                6: p.vel = '{32'sd46341, -32'sd46341, 32'sd1};
                default: begin
                    p.nrm = '{18'sd46341, 18'sd46341, 18'sd0};
                    p.vel = '{-32'sd300000, -32'sd100000, 32'sd77};
                end
            endcase
            send_particle(p);
        end
        end_burst();
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) send_particle(rand_particle());
        end_burst();
    endtask

    // one coefficient setting per phase, then random traffic
    task automatic test_coeff_sweep();
        logic [31:0] e_set [5] = '{32'd0, 32'd65536, 32'd32768, 32'd131071, 32'd6553};
        logic [31:0] f_set [5] = '{32'd0, 32'd262144, 32'd524287, 32'd16384, 32'd65536};
        for (int s = 0; s < 5; s++) begin
            drain_pipe();
            write_coeff(CFG_RESTITUTION, e_set[s]);
            write_coeff(CFG_FRICTION, f_set[s]);
            test_random(60);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_RESTITUTION;
        i_cfg_data = '0;
        {i_normal_x, i_normal_y, i_normal_z} = '0;
        {i_vel_x, i_vel_y, i_vel_z} = '0;
        {i_wall_vel_x, i_wall_vel_y, i_wall_vel_z} = '0;
        restitution_q = 0;
        friction_q = 0;
        fail_count = 0;
        send_gap_pct = 29;
        recv_stall_pct = 70;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        drain_pipe();
        write_coeff(CFG_RESTITUTION, 32'd52428);
        write_coeff(CFG_FRICTION, 32'd19661);
        test_directed();
        test_coeff_sweep();

        send_gap_pct = 70;
        recv_stall_pct = 29;
        test_random(120);
        drain_pipe();
        write_coeff(CFG_RESTITUTION, 32'd65536);
        write_coeff(CFG_FRICTION, 32'd262144);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random(200);

        drain_pipe();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/cvr_pkg.sv
rtl/core/cvr_isqrt.sv
rtl/core/cvr_div.sv
rtl/core/collision_velocity_response.sv
bench/tb_collision_velocity_response.sv
